>>> hdl/lvj_pkg.sv
// Shared types and character codes for the label/value text to JSON converter.
package lvj_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       truncated;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LEAD,
    ST_QUOTE_OPEN,
    ST_LABEL,
    ST_QUOTE_CLOSE,
    ST_COLON,
    ST_VALUE,
    ST_CLOSE
  } lvj_state_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

endpackage

>>> hdl/label_value_text_to_json_top.sv
// Top level of the label/value text to JSON converter.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_beat_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_beat_t)
//
// An input beat that closes no kept part is accepted in ST_IDLE, storing a
// non-separator byte while there is room, and judged in ST_CHECK. A kept part
// then streams 3 + part length bytes at one per cycle, label and value bytes
// prefetched from the single-read-port part memory into registered read data;
// the closing brace adds one more. Reset clears the sequencer and part counters
// at once; the part memory needs no clearing. A stalled output holds the
// sequencer in place, and no input beat is taken until the sequencer is idle.
module label_value_text_to_json_top
  import lvj_pkg::*;
#(
  parameter int PART_BYTES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int LW = $clog2(PART_BYTES + 1);
  localparam int AW = $clog2(PART_BYTES);

  // Sequencer state.
  lvj_state_e state_q, state_d;

  // Part bookkeeping.
  logic [LW-1:0] len_q;
  logic [LW-1:0] colon_pos_q;
  logic          colon_seen_q;
  logic          ovf_q;
  logic          any_emitted_q;
  logic          eom_q;
  logic          finish_q;

  // Read index into the part memory.
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] idx_inc;

  // Part memory with registered read data.
  logic [7:0]    part_mem [PART_BYTES];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // Handshake toward the output stage.
  logic      emit_valid;
  logic      emit_ready;
  out_beat_t emit_data;

  logic accept;
  logic is_sep;
  logic room;
  logic keep;
  logic part_clear;
  logic part_done;
  logic close_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  assign is_sep = (in_data_i.in_byte == CH_SPACE) || (in_data_i.in_byte == CH_TAB) ||
                  (in_data_i.in_byte == CH_COMMA);
  assign room   = (len_q < LW'(PART_BYTES));

  // A part is kept with a non-empty label before the first colon and a
  // non-empty value after it.
  assign keep = colon_seen_q && (colon_pos_q != '0) &&
                ({1'b0, len_q} > ({1'b0, colon_pos_q} + (LW + 1)'(1)));

  assign idx_inc = idx_q + LW'(1);

  assign wr_en   = accept && !is_sep && room;
  assign wr_addr = len_q[AW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (finish_q && keep) begin
          state_d = ST_LEAD;
        end else if (eom_q && any_emitted_q) begin
          state_d = ST_CLOSE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LEAD: begin
        if (emit_ready) begin
          state_d = ST_QUOTE_OPEN;
        end
      end
      ST_QUOTE_OPEN: begin
        if (emit_ready) begin
          state_d = ST_LABEL;
        end
      end
      ST_LABEL: begin
        if (emit_ready && (idx_inc == colon_pos_q)) begin
          state_d = ST_QUOTE_CLOSE;
        end
      end
      ST_QUOTE_CLOSE: begin
        if (emit_ready) begin
          state_d = ST_COLON;
        end
      end
      ST_COLON: begin
        if (emit_ready) begin
          state_d = ST_VALUE;
        end
      end
      ST_VALUE: begin
        if (emit_ready && (idx_inc == len_q)) begin
          state_d = eom_q ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (emit_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: emitted beat, read index, part updates.
  always_comb begin
    emit_valid           = 1'b0;
    emit_data.out_byte   = CH_QUOTE;
    emit_data.last       = 1'b0;
    emit_data.truncated  = ovf_q;
    idx_d                = idx_q;
    part_clear           = 1'b0;
    part_done            = 1'b0;
    close_done           = 1'b0;
    case (state_q)
      ST_CHECK: begin
        idx_d = '0;
        if (finish_q && !keep) begin
          part_clear = 1'b1;
        end
      end
      ST_LEAD: begin
        emit_valid         = 1'b1;
        emit_data.out_byte = any_emitted_q ? CH_COMMA : CH_OPEN;
      end
      ST_QUOTE_OPEN: begin
        emit_valid = 1'b1;
      end
      ST_LABEL: begin
        emit_valid         = 1'b1;
        emit_data.out_byte = rd_data_q;
        if (emit_ready) begin
          idx_d = idx_inc;
        end
      end
      ST_QUOTE_CLOSE: begin
        emit_valid = 1'b1;
        // Skip the colon itself; the value starts right after it.
        if (emit_ready) begin
          idx_d = idx_inc;
        end
      end
      ST_COLON: begin
        emit_valid         = 1'b1;
        emit_data.out_byte = CH_COLON;
      end
      ST_VALUE: begin
        emit_valid         = 1'b1;
        emit_data.out_byte = rd_data_q;
        if (emit_ready) begin
          idx_d = idx_inc;
          if (idx_inc == len_q) begin
            part_clear = 1'b1;
            part_done  = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        emit_valid          = 1'b1;
        emit_data.out_byte  = CH_CLOSE;
        emit_data.last      = 1'b1;
        emit_data.truncated = 1'b0;
        close_done          = emit_ready;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  // Prefetch the entry that the next cycle will show.
  assign rd_en   = (idx_d < LW'(PART_BYTES));
  assign rd_addr = idx_d[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      part_mem[wr_addr] <= in_data_i.in_byte;
    end
    if (rd_en) begin
      rd_data_q <= part_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      len_q         <= '0;
      colon_pos_q   <= '0;
      colon_seen_q  <= 1'b0;
      ovf_q         <= 1'b0;
      any_emitted_q <= 1'b0;
      eom_q         <= 1'b0;
      finish_q      <= 1'b0;
      idx_q         <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (accept) begin
        eom_q    <= in_data_i.end_of_message;
        finish_q <= is_sep || in_data_i.end_of_message;
        if (!is_sep) begin
          // Store while there is room, otherwise drop and flag the part.
          if (room) begin
            len_q <= len_q + LW'(1);
            if ((in_data_i.in_byte == CH_COLON) && !colon_seen_q) begin
              colon_seen_q <= 1'b1;
              colon_pos_q  <= len_q;
            end
          end else begin
            ovf_q <= 1'b1;
          end
        end
      end
      if (part_clear) begin
        len_q        <= '0;
        colon_pos_q  <= '0;
        colon_seen_q <= 1'b0;
        ovf_q        <= 1'b0;
      end
      if (part_done) begin
        any_emitted_q <= 1'b1;
      end
      if (close_done) begin
        any_emitted_q <= 1'b0;
      end
    end
  end

  lvj_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_valid_i (emit_valid),
    .emit_data_i  (emit_data),
    .emit_ready_o (emit_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // The part never holds more bytes than the memory has entries.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(PART_BYTES))
    else $error("part length exceeds part memory depth");

  // A held colon always lies inside the held bytes.
  a_colon_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    colon_seen_q |-> (colon_pos_q < len_q))
    else $error("colon position outside the held part");

  // An accepted beat is always followed by the judging cycle.
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CHECK))
    else $error("accepted beat not followed by part check");

  // A closing brace is only sent for a message that emitted a part.
  a_close_needs_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE) |-> any_emitted_q)
    else $error("closing brace without an emitted part");
`endif

endmodule

>>> hdl/lvj_out_reg.sv
// Output register stage that holds one JSON beat toward the downstream side.
module lvj_out_reg
  import lvj_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      emit_valid_i,
  input  out_beat_t emit_data_i,
  output logic      emit_ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic      valid_q, valid_d;
  out_beat_t data_q;

  // Load when empty or when the held beat leaves this cycle.
  assign emit_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_ready_o) begin
      valid_d = emit_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready_o && emit_valid_i) begin
      data_q <= emit_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
